// File: hdl/terminal_codon_damage_classifier_macros.svh
// Assertion macros shared by the classifier modules
`ifndef TERMINAL_CODON_DAMAGE_CLASSIFIER_MACROS_SVH
`define TERMINAL_CODON_DAMAGE_CLASSIFIER_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define TCDC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger
`define TCDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tcdc_pkg.sv
// Shared types, constants and lookup tables of the terminal codon damage classifier
`default_nettype none

package tcdc_pkg;

	// Codon limits
	localparam int MAX_TERMINAL_CODONS = 64;
	localparam int CODON_MAX           = 63;

	// Queue between classifier front and emitter back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Base codes, two bits per base
	localparam logic [1:0] BASE_T = 2'd0;
	localparam logic [1:0] BASE_A = 2'd2;

	// Read end codes
	localparam logic SIDE_FIVE  = 1'b0;
	localparam logic SIDE_THREE = 1'b1;

	typedef logic [7:0] amino_t;

	// Standard genetic code, indexed by codon code
	localparam amino_t AMINO_ROM [64] = '{
		"F","F","L","L", "S","S","S","S", "Y","Y","*","*", "C","C","*","W",
		"L","L","L","L", "P","P","P","P", "H","H","Q","Q", "R","R","R","R",
		"I","I","I","M", "T","T","T","T", "N","N","K","K", "S","S","R","R",
		"V","V","V","V", "A","A","A","A", "D","D","E","E", "G","G","G","G"
	};

	// One classified codon waiting for emission
	typedef struct packed {
		logic [5:0] idx;
		logic       side;
		logic       last;
		logic [2:0] site;
		logic [2:0] syn;
	} work_t;

	// Saturating count step
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

`default_nettype wire

// File: hdl/tcdc_front.sv
// Front end: accepts codon words and classifies their damage sites
`default_nettype none

module tcdc_front
	import tcdc_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] codon,
	input  wire logic [5:0] codon_index,
	input  wire logic       end_side,
	input  wire logic       last_codon,
	input  wire logic [7:0] reach_limit,
	output logic            push_valid,
	input  wire logic       push_ready,
	output work_t           push_data
);

	logic       codon_ok;
	logic [7:0] idx3;
	logic [5:0] code6;
	logic [2:0] site;
	logic [2:0] syn;

	assign code6    = codon[5:0];
	assign codon_ok = (codon <= 8'(CODON_MAX))
		&& (7'(codon_index) < 7'(MAX_TERMINAL_CODONS));
	assign idx3     = 8'({codon_index, 1'b0}) + 8'(codon_index);

	// Classify each base position independently
	always_comb begin
		logic [7:0] term_dist;
		logic [1:0] base;
		logic [5:0] flip;
		for (int p = 0; p < 3; p++) begin
			term_dist = (end_side == SIDE_THREE) ? idx3 + 8'(2 - p) : idx3 + 8'(p);
			base = code6[5 - 2 * p -: 2];
			flip = code6 ^ (6'd1 << (4 - 2 * p));
			site[p] = codon_ok && (term_dist < reach_limit)
				&& (base == ((end_side == SIDE_THREE) ? BASE_A : BASE_T));
			syn[p]  = AMINO_ROM[code6] == AMINO_ROM[flip];
		end
	end

	// Push only words that produce at least one result
	assign in_ready             = push_ready;
	assign push_valid           = in_valid && ((|site) || last_codon);
	assign push_data.idx        = codon_index;
	assign push_data.side       = end_side;
	assign push_data.last       = last_codon;
	assign push_data.site       = site;
	assign push_data.syn        = syn;

endmodule

`default_nettype wire

// File: hdl/tcdc_queue.sv
// Short register queue between the classifier front and the emitter back
`default_nettype none
`include "terminal_codon_damage_classifier_macros.svh"

module tcdc_queue
	import tcdc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  work_t     push_data,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output work_t     pop_data
);

	work_t             entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TCDC_ASSERT_NEXT(a_fill_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue fill count did not rise on push")
	`TCDC_ASSERT_NEXT(a_fill_down, pop && !push, count_q == $past(count_q) - 1'b1, "queue fill count did not fall on pop")

endmodule

`default_nettype wire

// File: hdl/tcdc_back.sv
// Back end: emits site and summary words one per cycle while out_ready holds, keeps running totals
`default_nettype none
`include "terminal_codon_damage_classifier_macros.svh"

module tcdc_back
	import tcdc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  work_t     pop_data,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic       is_site,
	output logic [5:0] site_codon,
	output logic [1:0] site_position,
	output logic       damage_kind,
	output logic       synonymous,
	output logic [7:0] syn_five_count,
	output logic [7:0] nonsyn_five_count,
	output logic [7:0] syn_three_count,
	output logic [7:0] nonsyn_three_count,
	output logic       any_synonymous,
	output logic       last_of_run
);

	work_t      cur_q;
	logic [7:0] syn5_q, non5_q, syn3_q, non3_q;
	logic       seen_q;

	logic       out_valid_q, is_site_q, kind_q, syn_out_q, any_q, last_q;
	logic [5:0] codon_q;
	logic [1:0] pos_q;
	logic [7:0] c_syn5_q, c_non5_q, c_syn3_q, c_non3_q;

	logic       busy, out_free, emit, emit_site, emit_sum, rem_empty, finishing, pop;
	logic [1:0] sel_pos;
	logic       sel_syn;
	logic [2:0] rem_site;
	logic [7:0] syn5_d, non5_d, syn3_d, non3_d;

	assign busy      = (|cur_q.site) || cur_q.last;
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = out_free && busy;
	assign emit_site = emit && (|cur_q.site);
	assign emit_sum  = emit && !(|cur_q.site);

	// Pick the lowest pending base position
	always_comb begin
		if (cur_q.site[0]) begin
			sel_pos  = 2'd0;
			rem_site = {cur_q.site[2:1], 1'b0};
		end else if (cur_q.site[1]) begin
			sel_pos  = 2'd1;
			rem_site = {cur_q.site[2], 2'b00};
		end else begin
			sel_pos  = 2'd2;
			rem_site = 3'b000;
		end
		sel_syn = cur_q.syn[sel_pos];
	end

	assign rem_empty = emit_sum || ((rem_site == 3'b000) && !cur_q.last);
	assign finishing = !busy || (emit && rem_empty);
	assign pop_ready = finishing;
	assign pop       = pop_valid && finishing;

	// Step the total that this site hits
	always_comb begin
		syn5_d = syn5_q;
		non5_d = non5_q;
		syn3_d = syn3_q;
		non3_d = non3_q;
		if (emit_site) begin
			case ({cur_q.side, sel_syn})
				{SIDE_FIVE, 1'b1}:  syn5_d = sat_inc(syn5_q);
				{SIDE_FIVE, 1'b0}:  non5_d = sat_inc(non5_q);
				{SIDE_THREE, 1'b1}: syn3_d = sat_inc(syn3_q);
				default:            non3_d = sat_inc(non3_q);
			endcase
		end
	end

	// Load the next word or drop emitted positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (pop) begin
			cur_q <= pop_data;
		end else if (emit) begin
			cur_q.site <= rem_site;
			if (emit_sum) begin
				cur_q.last <= 1'b0;
			end
		end
	end

	// Update running totals, clear after the summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syn5_q <= '0;
			non5_q <= '0;
			syn3_q <= '0;
			non3_q <= '0;
			seen_q <= 1'b0;
		end else if (emit_sum) begin
			syn5_q <= '0;
			non5_q <= '0;
			syn3_q <= '0;
			non3_q <= '0;
			seen_q <= 1'b0;
		end else if (emit_site) begin
			syn5_q <= syn5_d;
			non5_q <= non5_d;
			syn3_q <= syn3_d;
			non3_q <= non3_d;
			seen_q <= seen_q || sel_syn;
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			is_site_q <= emit_site;
			codon_q   <= emit_site ? cur_q.idx : 6'd0;
			pos_q     <= emit_site ? sel_pos : 2'd0;
			kind_q    <= emit_site ? cur_q.side : 1'b0;
			syn_out_q <= emit_site ? sel_syn : 1'b0;
			c_syn5_q  <= syn5_d;
			c_non5_q  <= non5_d;
			c_syn3_q  <= syn3_d;
			c_non3_q  <= non3_d;
			any_q     <= seen_q || (emit_site && sel_syn);
			last_q    <= rem_empty;
		end
	end

	assign out_valid          = out_valid_q;
	assign is_site            = is_site_q;
	assign site_codon         = codon_q;
	assign site_position      = pos_q;
	assign damage_kind        = kind_q;
	assign synonymous         = syn_out_q;
	assign syn_five_count     = c_syn5_q;
	assign nonsyn_five_count  = c_non5_q;
	assign syn_three_count    = c_syn3_q;
	assign nonsyn_three_count = c_non3_q;
	assign any_synonymous     = any_q;
	assign last_of_run        = last_q;

	`TCDC_ASSERT_NEXT(a_sum_clears, emit_sum, (syn5_q == 8'd0) && (non5_q == 8'd0) && (syn3_q == 8'd0) && (non3_q == 8'd0) && !seen_q, "totals not cleared after summary")
	`TCDC_ASSERT_SAME(a_sum_is_last, out_valid_q && !is_site_q, last_q, "summary word not marked last")
	`TCDC_ASSERT_NEXT(a_site_step, emit_site && !pop, $countones(cur_q.site) == $past($countones(cur_q.site)) - 1, "site emission did not retire one position")

endmodule

`default_nettype wire

// File: hdl/terminal_codon_damage_classifier.sv
// Accepted words pass the queue and the emitter word register to the output registers.
// Throughput: one result word per cycle while out_ready is high and words are queued;
// a codon gives a word per site and a summary if last; codons without results are dropped.
// Input accepts every cycle while the 4-entry queue between classifier and emitter has room.
// Reset (arst_n low, asynchronous): queue emptied, totals and reach_limit cleared to zero.
`default_nettype none

module terminal_codon_damage_classifier
	import tcdc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] reach_limit,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] codon,
	input  wire logic [5:0] codon_index,
	input  wire logic       end_side,
	input  wire logic       last_codon,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            is_site,
	output logic [5:0]      site_codon,
	output logic [1:0]      site_position,
	output logic            damage_kind,
	output logic            synonymous,
	output logic [7:0]      syn_five_count,
	output logic [7:0]      nonsyn_five_count,
	output logic [7:0]      syn_three_count,
	output logic [7:0]      nonsyn_three_count,
	output logic            any_synonymous,
	output logic            last_of_run
);

	logic [7:0] reach_limit_q;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	work_t      push_data, pop_data;

	// Hold the distance cutoff register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_limit_q <= '0;
		end else if (cfg_valid) begin
			reach_limit_q <= reach_limit;
		end
	end

	tcdc_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.codon       (codon),
		.codon_index (codon_index),
		.end_side    (end_side),
		.last_codon  (last_codon),
		.reach_limit (reach_limit_q),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	tcdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tcdc_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.pop_valid          (pop_valid),
		.pop_ready          (pop_ready),
		.pop_data           (pop_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.is_site            (is_site),
		.site_codon         (site_codon),
		.site_position      (site_position),
		.damage_kind        (damage_kind),
		.synonymous         (synonymous),
		.syn_five_count     (syn_five_count),
		.nonsyn_five_count  (nonsyn_five_count),
		.syn_three_count    (syn_three_count),
		.nonsyn_three_count (nonsyn_three_count),
		.any_synonymous     (any_synonymous),
		.last_of_run        (last_of_run)
	);

endmodule

`default_nettype wire
